>>> hdl/esp3_pkg.sv
// Shared types, codes and the CRC8 update for the ESP3 packet receiver.
// Used by the controller, the datapath, the top level and the checker.
package esp3_pkg;

	localparam logic [7:0]  SYNC_BYTE   = 8'h55;
	localparam logic [7:0]  CRC_POLY    = 8'h07;
	localparam logic [15:0] MAX_LEN_RST = 16'hFFFF;
	localparam int          HDR_BYTES   = 6;
	localparam int          FILL_W      = 3;

	// Byte roles.
	localparam logic [2:0] ROLE_DISCARD  = 3'd0;
	localparam logic [2:0] ROLE_SYNC     = 3'd1;
	localparam logic [2:0] ROLE_HDR      = 3'd2;
	localparam logic [2:0] ROLE_HDR_CRC  = 3'd3;
	localparam logic [2:0] ROLE_DATA     = 3'd4;
	localparam logic [2:0] ROLE_OPT      = 3'd5;
	localparam logic [2:0] ROLE_DATA_CRC = 3'd6;

	// Status codes.
	localparam logic [2:0] STAT_BUSY     = 3'd0;
	localparam logic [2:0] STAT_NO_SYNC  = 3'd1;
	localparam logic [2:0] STAT_OK       = 3'd2;
	localparam logic [2:0] STAT_HDR_ERR  = 3'd3;
	localparam logic [2:0] STAT_ZERO_LEN = 3'd4;
	localparam logic [2:0] STAT_DATA_ERR = 3'd5;
	localparam logic [2:0] STAT_TOO_LONG = 3'd6;

	// Protocol position within a packet.
	typedef enum logic [3:0] {
		ST_HUNT     = 4'd0,
		ST_LEN_HI   = 4'd1,
		ST_LEN_LO   = 4'd2,
		ST_OPT_LEN  = 4'd3,
		ST_TYPE     = 4'd4,
		ST_HDR_CRC  = 4'd5,
		ST_DATA     = 4'd6,
		ST_OPT      = 4'd7,
		ST_DATA_CRC = 4'd8
	} step_t;

	// Controller states.
	typedef enum logic {
		CTL_IDLE   = 1'b0,
		CTL_REPLAY = 1'b1
	} ctl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic exec_in;   // process the held input byte
		logic replay;    // push one stored header byte through the parser
		logic finish;    // publish the result of a header CRC error item
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic item_ready;   // a byte is held and the output register is free
		logic hdr_err;      // the held byte fails the header CRC check
		logic replay_more;  // stored header bytes remain to be replayed
	} dp_stat_t;

	function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

>>> hdl/esp3_ctrl.sv
// Sequencing controller of the ESP3 packet receiver.
// Depends on esp3_pkg for the state type and the command and status structs.
module esp3_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  esp3_pkg::dp_stat_t  stat,
	output esp3_pkg::dp_cmd_t   cmd
);

	esp3_pkg::ctl_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esp3_pkg::CTL_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			esp3_pkg::CTL_IDLE: begin
				if (stat.item_ready && stat.hdr_err) begin
					state_n = esp3_pkg::CTL_REPLAY;
				end
			end
			esp3_pkg::CTL_REPLAY: begin
				if (!stat.replay_more) begin
					state_n = esp3_pkg::CTL_IDLE;
				end
			end
			default: state_n = esp3_pkg::CTL_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			esp3_pkg::CTL_IDLE: begin
				cmd.exec_in = stat.item_ready;
			end
			esp3_pkg::CTL_REPLAY: begin
				cmd.replay = stat.replay_more;
				cmd.finish = !stat.replay_more;
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> hdl/esp3_dp.sv
// Datapath of the ESP3 packet receiver: parser registers, CRCs, header store,
// input holding register and output register. Depends on esp3_pkg.
module esp3_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  esp3_pkg::dp_cmd_t   cmd,
	output esp3_pkg::dp_stat_t  stat,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_valid,
	input  logic [15:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic [2:0]          byte_role,
	output logic [2:0]          status,
	output logic                frame_end,
	output logic [7:0]          packet_type,
	output logic [15:0]         data_length,
	output logic [7:0]          optional_length
);

	localparam int FW = esp3_pkg::FILL_W;

	// Parser state.
	esp3_pkg::step_t step_q, n_step;
	logic [7:0]      hcrc_q, n_hcrc;
	logic [7:0]      dcrc_q, n_dcrc;
	logic [15:0]     dlen_q, n_dlen;
	logic [7:0]      olen_q, n_olen;
	logic [7:0]      type_q, n_type;
	logic [15:0]     fcnt_q, n_fcnt;
	logic [16:0]     pcnt_q, n_pcnt;
	logic [FW-1:0]   fill_q, n_fill;
	logic [7:0]      store_q [esp3_pkg::HDR_BYTES];
	logic [15:0]     max_len_q;

	// Item handling.
	logic [7:0]      byte_q;
	logic            hold_q;
	logic [FW-1:0]   rp_idx_q, rp_end_q;
	logic [2:0]      res_role_q, res_status_q;
	logic            res_end_q;

	// Output register.
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic [2:0]      out_role_q, out_status_q;
	logic            out_end_q;
	logic [7:0]      out_type_q;
	logic [15:0]     out_dlen_q;
	logic [7:0]      out_olen_q;

	// Parser step outputs.
	logic [7:0]      c;
	logic [2:0]      n_role, n_status;
	logic            n_end;
	logic            wr_en;
	logic [FW-1:0]   wr_idx;
	logic [15:0]     fc1;
	logic [15:0]     len_lo;
	logic [16:0]     pc1;
	logic            upd, out_free, load_direct;

	assign out_free    = !out_valid_q || !out_stall;
	assign upd         = cmd.exec_in || cmd.replay;
	assign load_direct = cmd.exec_in && !stat.hdr_err;

	assign stat.item_ready  = hold_q && out_free;
	assign stat.hdr_err     = (step_q == esp3_pkg::ST_HDR_CRC) && (byte_q != hcrc_q);
	assign stat.replay_more = rp_idx_q < rp_end_q;

	assign c = cmd.replay ? store_q[rp_idx_q] : byte_q;

	// One parser step on byte c.
	always_comb begin
		n_step   = step_q;
		n_hcrc   = hcrc_q;
		n_dcrc   = dcrc_q;
		n_dlen   = dlen_q;
		n_olen   = olen_q;
		n_type   = type_q;
		n_fcnt   = fcnt_q;
		n_pcnt   = pcnt_q;
		n_fill   = fill_q;
		n_role   = esp3_pkg::ROLE_DISCARD;
		n_status = esp3_pkg::STAT_BUSY;
		n_end    = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = fill_q;
		fc1      = fcnt_q + 16'd1;
		pc1      = pcnt_q + 17'd1;
		len_lo   = {dlen_q[7:0], c};

		// Header bytes after the sync byte are kept for a possible resync.
		if ((step_q >= esp3_pkg::ST_LEN_HI) && (step_q <= esp3_pkg::ST_HDR_CRC) &&
				(fill_q < FW'(esp3_pkg::HDR_BYTES))) begin
			wr_en  = 1'b1;
			n_fill = fill_q + FW'(1);
		end

		unique case (step_q)
			esp3_pkg::ST_LEN_HI: begin
				n_dlen = {8'd0, c};
				n_hcrc = esp3_pkg::crc8_upd(hcrc_q, c);
				n_pcnt = pc1;
				n_step = esp3_pkg::ST_LEN_LO;
				n_role = esp3_pkg::ROLE_HDR;
			end
			esp3_pkg::ST_LEN_LO: begin
				n_dlen = len_lo;
				n_hcrc = esp3_pkg::crc8_upd(hcrc_q, c);
				n_role = esp3_pkg::ROLE_HDR;
				if (len_lo == 16'd0) begin
					n_status = esp3_pkg::STAT_ZERO_LEN;
					n_end    = 1'b1;
					n_step   = esp3_pkg::ST_HUNT;
					n_fill   = '0;
				end else begin
					n_pcnt = pc1;
					n_step = esp3_pkg::ST_OPT_LEN;
				end
			end
			esp3_pkg::ST_OPT_LEN: begin
				n_olen = c;
				n_hcrc = esp3_pkg::crc8_upd(hcrc_q, c);
				n_pcnt = pc1;
				n_step = esp3_pkg::ST_TYPE;
				n_role = esp3_pkg::ROLE_HDR;
			end
			esp3_pkg::ST_TYPE: begin
				n_type = c;
				n_hcrc = esp3_pkg::crc8_upd(hcrc_q, c);
				n_pcnt = pc1;
				n_step = esp3_pkg::ST_HDR_CRC;
				n_role = esp3_pkg::ROLE_HDR;
			end
			esp3_pkg::ST_HDR_CRC: begin
				n_role = esp3_pkg::ROLE_HDR_CRC;
				if (c != hcrc_q) begin
					n_status = esp3_pkg::STAT_HDR_ERR;
					n_end    = 1'b1;
					n_step   = esp3_pkg::ST_HUNT;
				end else begin
					n_dcrc = 8'd0;
					n_pcnt = pc1;
					n_fcnt = 16'd0;
					n_step = esp3_pkg::ST_DATA;
				end
			end
			esp3_pkg::ST_DATA: begin
				n_role = esp3_pkg::ROLE_DATA;
				n_dcrc = esp3_pkg::crc8_upd(dcrc_q, c);
				n_pcnt = pc1;
				if (fc1 >= dlen_q) begin
					n_step = (olen_q != 8'd0) ? esp3_pkg::ST_OPT : esp3_pkg::ST_DATA_CRC;
					n_fcnt = 16'd0;
				end else begin
					n_fcnt = fc1;
				end
			end
			esp3_pkg::ST_OPT: begin
				n_role = esp3_pkg::ROLE_OPT;
				n_dcrc = esp3_pkg::crc8_upd(dcrc_q, c);
				n_pcnt = pc1;
				n_fcnt = fc1;
				if (fc1 >= {8'd0, olen_q}) begin
					n_step = esp3_pkg::ST_DATA_CRC;
				end
			end
			esp3_pkg::ST_DATA_CRC: begin
				n_role = esp3_pkg::ROLE_DATA_CRC;
				n_end  = 1'b1;
				n_step = esp3_pkg::ST_HUNT;
				n_fill = '0;
				if (c != dcrc_q) begin
					n_status = esp3_pkg::STAT_DATA_ERR;
				end else begin
					n_pcnt   = pc1;
					n_status = (pc1 > {1'b0, max_len_q}) ? esp3_pkg::STAT_TOO_LONG
					                                     : esp3_pkg::STAT_OK;
				end
			end
			default: begin
				// Hunting for the sync byte.
				if (c == esp3_pkg::SYNC_BYTE) begin
					n_hcrc = 8'd0;
					n_dcrc = 8'd0;
					n_dlen = 16'd0;
					n_olen = 8'd0;
					wr_en  = 1'b1;
					wr_idx = '0;
					n_fill = FW'(1);
					n_pcnt = 17'd1;
					n_step = esp3_pkg::ST_LEN_HI;
					n_role = esp3_pkg::ROLE_SYNC;
				end else begin
					n_fill   = '0;
					n_status = esp3_pkg::STAT_NO_SYNC;
				end
			end
		endcase
	end

	// Parser registers. A header CRC error rewinds to hunting and arms the replay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= esp3_pkg::ST_HUNT;
			hcrc_q   <= '0;
			dcrc_q   <= '0;
			dlen_q   <= '0;
			olen_q   <= '0;
			type_q   <= '0;
			fcnt_q   <= '0;
			pcnt_q   <= '0;
			fill_q   <= '0;
			rp_idx_q <= '0;
			rp_end_q <= '0;
		end else if (upd) begin
			hcrc_q <= n_hcrc;
			dcrc_q <= n_dcrc;
			dlen_q <= n_dlen;
			olen_q <= n_olen;
			type_q <= n_type;
			fcnt_q <= n_fcnt;
			pcnt_q <= n_pcnt;
			if (cmd.exec_in && stat.hdr_err) begin
				step_q   <= esp3_pkg::ST_HUNT;
				fill_q   <= '0;
				rp_idx_q <= FW'(1);
				rp_end_q <= n_fill;
			end else begin
				step_q <= n_step;
				fill_q <= n_fill;
				if (cmd.replay) begin
					rp_idx_q <= rp_idx_q + FW'(1);
				end
			end
		end
	end

	// Header store. Replay writes always land below the entry being read.
	always_ff @(posedge clk) begin
		if (upd && wr_en) begin
			store_q[wr_idx] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= esp3_pkg::MAX_LEN_RST;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// Input holding register.
	assign in_stall = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_valid && !hold_q) begin
			hold_q <= 1'b1;
		end else if (load_direct || cmd.finish) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !hold_q) begin
			byte_q <= rx_byte;
		end
		if (cmd.exec_in) begin
			res_role_q   <= n_role;
			res_status_q <= n_status;
			res_end_q    <= n_end;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_byte_q   <= byte_q;
			out_role_q   <= n_role;
			out_status_q <= n_status;
			out_end_q    <= n_end;
			out_type_q   <= n_type;
			out_dlen_q   <= n_dlen;
			out_olen_q   <= n_olen;
		end else if (cmd.finish) begin
			out_byte_q   <= byte_q;
			out_role_q   <= res_role_q;
			out_status_q <= res_status_q;
			out_end_q    <= res_end_q;
			out_type_q   <= type_q;
			out_dlen_q   <= dlen_q;
			out_olen_q   <= olen_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign byte_role       = out_role_q;
	assign status          = out_status_q;
	assign frame_end       = out_end_q;
	assign packet_type     = out_type_q;
	assign data_length     = out_dlen_q;
	assign optional_length = out_olen_q;

endmodule

>>> hdl/esp3_packet_receiver.sv
// Top level of the ESP3 serial packet receiver.
// Instantiates esp3_ctrl and esp3_dp; uses types from esp3_pkg.
//
// The input channel (in_valid, in_stall, rx_byte) takes one received serial
// byte per item, and every item yields exactly one result item on the output
// channel (out_valid, out_stall and the payload ports): the byte, its role in
// the packet, a status, a frame end flag, and the packet type and lengths of
// the current header after that byte. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) writes the largest accepted packet length; it is always
// ready and should be written only while the receiver holds no item.
// An accepted byte sits in a one-entry holding register; once the output
// register is free, the parser loads its result there, and the holding register
// frees on that same edge, so the block takes no new byte until the held byte's
// result is loaded. A byte that fails the header CRC starts a replay instead:
// the five stored header bytes after the sync byte are walked back
// through the parser, one per cycle, before the result is published.
// When the receiver stalls, the result stays in the output register and one
// more byte enters the holding register; then the input stalls until the
// output frees. Reset clears the parser to hunting for sync, both CRCs,
// lengths, packet type and counters, and sets the maximum length to 65535.
module esp3_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [2:0]  byte_role,
	output logic [2:0]  status,
	output logic        frame_end,
	output logic [7:0]  packet_type,
	output logic [15:0] data_length,
	output logic [7:0]  optional_length
);

	esp3_pkg::dp_cmd_t  cmd;
	esp3_pkg::dp_stat_t stat;

	// The port is always open; the block itself does not keep register writes apart from parsing.
	assign cfg_ready = 1'b1;

	esp3_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	esp3_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.byte_role       (byte_role),
		.status          (status),
		.frame_end       (frame_end),
		.packet_type     (packet_type),
		.data_length     (data_length),
		.optional_length (optional_length)
	);

endmodule

>>> hdl/esp3_checker.sv
// Port-level checker for the ESP3 packet receiver, bound to the top level.
// Depends on esp3_pkg for role and status codes.
module esp3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic [2:0]  byte_role,
	input logic [2:0]  status,
	input logic        frame_end,
	input logic [15:0] data_length,
	input logic [7:0]  optional_length
);

	// A frame can only end on a header field, the header CRC or the data CRC.
	a_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (byte_role == esp3_pkg::ROLE_HDR ||
			byte_role == esp3_pkg::ROLE_HDR_CRC || byte_role == esp3_pkg::ROLE_DATA_CRC))
		else $error("frame end on a byte that cannot close a packet");

	// A byte seen while hunting that is not the sync byte is discarded and never ends a frame.
	a_no_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == esp3_pkg::STAT_NO_SYNC) |->
			(byte_role == esp3_pkg::ROLE_DISCARD && !frame_end))
		else $error("no-sync status on a byte that is not discarded");

	// A sync byte starts a new header with both lengths cleared.
	a_sync_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_role == esp3_pkg::ROLE_SYNC) |->
			(data_length == 16'd0 && optional_length == 8'd0 && out_byte == esp3_pkg::SYNC_BYTE))
		else $error("sync result without cleared lengths");

	// A stalled result stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind esp3_packet_receiver esp3_checker u_esp3_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.out_byte        (out_byte),
	.byte_role       (byte_role),
	.status          (status),
	.frame_end       (frame_end),
	.data_length     (data_length),
	.optional_length (optional_length)
);
